### design/bisection_cubic_root_finder_unit_defines.svh
// Assertion macros for the bisection cubic root finder.
`ifndef BISECTION_CUBIC_ROOT_FINDER_UNIT_DEFINES_SVH
`define BISECTION_CUBIC_ROOT_FINDER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define BCRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define BCRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bcrf_pkg.sv
// Shared constants, types and microcode encodings of the bisection root finder.
package bcrf_pkg;

  localparam int unsigned MAX_ITER  = 40;
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned XW     = 32;           // bracket / midpoint width
  localparam int unsigned TOL_W  = 31;
  localparam int unsigned STEP_W = 7;
  localparam int unsigned HALF   = 32;           // split of x^2 for the multiplier
  localparam int unsigned MW     = XW + 1;       // multiplier operand width
  localparam int unsigned PW     = 2 * MW;       // product width
  localparam int unsigned LIN_W  = XW + 5;       // 10x - 20s
  localparam int unsigned ACC_W  = 98;           // exact cubic, units 2^-3F
  localparam int unsigned SH_W   = ACC_W - 2 * FRAC_BITS;

  localparam logic [MW-1:0]    TWO_S    = MW'(2) << FRAC_BITS;
  localparam logic [LIN_W-1:0] TWENTY_S = LIN_W'(20) << FRAC_BITS;

  localparam logic [XW-1:0] Q_MAX = {1'b0, {(XW-1){1'b1}}};
  localparam logic [XW-1:0] Q_MIN = {1'b1, {(XW-1){1'b0}}};

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_SAME_SIGN = 2'd1;
  localparam logic [1:0] ST_NO_STEP   = 2'd2;

  typedef enum logic [3:0] {
    S_EVL0, S_EVL1, S_EVL2,
    S_EVR0, S_EVR1, S_EVR2,
    S_CHK,  S_KLP,  S_MID,
    S_EVM0, S_EVM1, S_EVM2,
    S_DEC
  } step_e;

  typedef enum logic [1:0] { XS_L, XS_R, XS_M } xsel_e;
  typedef enum logic [1:0] { AOP_NONE, AOP_INIT, AOP_LO, AOP_HI } aop_e;
  typedef enum logic [2:0] {
    ACT_NONE, ACT_SGN_L, ACT_CHK, ACT_KLOOP, ACT_MID, ACT_DEC
  } act_e;
  typedef enum logic [1:0] { JC_NEXT, JC_KMORE, JC_LOOP } jc_e;

  typedef struct packed {
    xsel_e xsel;
    aop_e  aop;
    act_e  act;
    jc_e   jc;
    step_e target;
  } ctrl_t;

  typedef struct packed {
    logic signed [XW-1:0] left_end;
    logic signed [XW-1:0] right_end;
    logic [TOL_W-1:0]     tolerance;
  } item_t;

  typedef struct packed {
    logic signed [XW-1:0] root_estimate;
    logic signed [XW-1:0] value_at_root;
    logic [STEP_W-1:0]    steps_taken;
    logic [1:0]           status;
  } res_t;

  typedef struct packed {
    logic kmore;      // step count still growing
    logic same_sign;  // ends share a nonzero sign
    logic last;       // current bisection step is the final one
  } flags_t;

  typedef struct packed {
    logic accept;
    logic run;
    logic finish;
  } seq_t;

endpackage

### design/bcrf_ucode_rom.sv
// Microcode table: one control word per sequencer step.
module bcrf_ucode_rom import bcrf_pkg::*; (
  input  step_e step_i,
  output ctrl_t ctrl_o
);

  always_comb begin
    ctrl_o = '{xsel: XS_L, aop: AOP_NONE, act: ACT_NONE, jc: JC_NEXT, target: S_EVL0};
    case (step_i)
      S_EVL0: begin
        ctrl_o.xsel = XS_L;
        ctrl_o.aop  = AOP_INIT;
      end
      S_EVL1: begin
        ctrl_o.xsel = XS_L;
        ctrl_o.aop  = AOP_LO;
      end
      S_EVL2: begin
        ctrl_o.xsel = XS_L;
        ctrl_o.aop  = AOP_HI;
      end
      S_EVR0: begin
        ctrl_o.xsel = XS_R;
        ctrl_o.aop  = AOP_INIT;
        ctrl_o.act  = ACT_SGN_L;   // acc still holds p(left)
      end
      S_EVR1: begin
        ctrl_o.xsel = XS_R;
        ctrl_o.aop  = AOP_LO;
      end
      S_EVR2: begin
        ctrl_o.xsel = XS_R;
        ctrl_o.aop  = AOP_HI;
      end
      S_CHK: begin
        ctrl_o.act = ACT_CHK;
      end
      S_KLP: begin
        ctrl_o.act    = ACT_KLOOP;
        ctrl_o.jc     = JC_KMORE;
        ctrl_o.target = S_KLP;
      end
      S_MID: begin
        ctrl_o.act = ACT_MID;
      end
      S_EVM0: begin
        ctrl_o.xsel = XS_M;
        ctrl_o.aop  = AOP_INIT;
      end
      S_EVM1: begin
        ctrl_o.xsel = XS_M;
        ctrl_o.aop  = AOP_LO;
      end
      S_EVM2: begin
        ctrl_o.xsel = XS_M;
        ctrl_o.aop  = AOP_HI;
      end
      S_DEC: begin
        ctrl_o.act    = ACT_DEC;
        ctrl_o.jc     = JC_LOOP;
        ctrl_o.target = S_MID;
      end
      default: begin
        ctrl_o.act = ACT_NONE;
      end
    endcase
  end

endmodule

### design/bcrf_datapath.sv
// Datapath: bracket registers, shared multiplier, wide accumulator, step counters.
module bcrf_datapath import bcrf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  item_t  item_i,
  input  ctrl_t  ctrl_i,
  input  seq_t   seq_i,
  output flags_t flags_o,
  output res_t   res_o
);

  typedef struct packed {
    logic neg;
    logic nz;
  } sgn_t;

  logic signed [XW-1:0]    lft_q, lft_d, rgt_q, rgt_d, x_q, x_d;
  logic [TOL_W-1:0]        tol_q, tol_d;
  logic [XW:0]             t_q, t_d;
  logic [STEP_W-1:0]       k_q, k_d, i_q, i_d, i_next;
  logic [2*HALF-1:0]       sq_q, sq_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  sgn_t                    sl_q, sl_d, sr_q, sr_d, sm;

  logic signed [XW-1:0]    xs;
  logic signed [MW-1:0]    xp2, ma, mb;
  logic signed [PW-1:0]    prod;
  logic signed [LIN_W-1:0] xe, lin;
  logic signed [ACC_W-1:0] acc_init, prod_ext, tol_w, tol_sum;
  logic signed [XW:0]      wid, mid_sum;
  logic [SH_W-1:0]         sh;
  logic [SH_W-XW:0]        sh_top;
  logic [XW-1:0]           q_val;
  logic                    near_zero, kmore, last;

  // operand select
  always_comb begin
    case (ctrl_i.xsel)
      XS_L:    xs = lft_q;
      XS_R:    xs = rgt_q;
      XS_M:    xs = x_q;
      default: xs = x_q;
    endcase
  end

  assign xp2 = MW'(xs) + $signed(TWO_S);

  always_comb begin
    case (ctrl_i.aop)
      AOP_INIT: begin
        ma = MW'(xs);
        mb = MW'(xs);
      end
      AOP_LO: begin
        ma = $signed({1'b0, sq_q[HALF-1:0]});
        mb = xp2;
      end
      AOP_HI: begin
        ma = $signed({1'b0, sq_q[2*HALF-1:HALF]});
        mb = xp2;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod     = PW'(ma) * PW'(mb);
  assign prod_ext = ACC_W'(prod);

  // linear and constant terms: (10x - 20s) << 2F
  assign xe       = LIN_W'(xs);
  assign lin      = (xe <<< 3) + (xe <<< 1) - $signed(TWENTY_S);
  assign acc_init = $signed({{(ACC_W-LIN_W-2*FRAC_BITS){lin[LIN_W-1]}}, lin,
                             {(2*FRAC_BITS){1'b0}}});

  // |p(mid)| <= tol, both in units 2^-3F
  assign tol_w     = $signed({{(ACC_W-TOL_W-2*FRAC_BITS){1'b0}}, tol_q,
                              {(2*FRAC_BITS){1'b0}}});
  assign tol_sum   = acc_q + tol_w;
  assign near_zero = acc_q[ACC_W-1] ? !tol_sum[ACC_W-1] : (acc_q <= tol_w);

  assign sm = '{neg: acc_q[ACC_W-1], nz: |acc_q};

  // floor shift by 2F, saturate
  assign sh     = acc_q[ACC_W-1:2*FRAC_BITS];
  assign sh_top = sh[SH_W-1:XW-1];
  assign q_val  = ((&sh_top) || !(|sh_top)) ? sh[XW-1:0]
                : (acc_q[ACC_W-1] ? Q_MIN : Q_MAX);

  assign wid     = (XW+1)'(rgt_q) - (XW+1)'(lft_q);
  assign mid_sum = (XW+1)'(lft_q) + (XW+1)'(rgt_q);
  assign kmore   = (k_q < STEP_W'(MAX_ITER)) && !wid[XW] && (|wid)
                && ($unsigned(wid) > t_q);
  assign i_next  = i_q + STEP_W'(1);
  assign last    = (k_q == '0) || (i_next == k_q);

  assign flags_o.kmore     = kmore;
  assign flags_o.last      = last;
  assign flags_o.same_sign = sl_q.nz && sm.nz && (sl_q.neg == sm.neg);

  always_comb begin
    if (ctrl_i.act == ACT_CHK) begin
      res_o = '{root_estimate: '0, value_at_root: '0, steps_taken: '0,
                status: ST_SAME_SIGN};
    end else begin
      res_o.root_estimate = x_q;
      res_o.value_at_root = $signed(q_val);
      res_o.steps_taken   = k_q;
      res_o.status        = (k_q == '0) ? ST_NO_STEP : ST_CONVERGED;
    end
  end

  always_comb begin
    lft_d = lft_q;
    rgt_d = rgt_q;
    tol_d = tol_q;
    t_d   = t_q;
    k_d   = k_q;
    i_d   = i_q;
    x_d   = x_q;
    sq_d  = sq_q;
    acc_d = acc_q;
    sl_d  = sl_q;
    sr_d  = sr_q;
    if (seq_i.accept) begin
      lft_d = item_i.left_end;
      rgt_d = item_i.right_end;
      tol_d = item_i.tolerance;
      t_d   = (XW+1)'(item_i.tolerance);
      k_d   = '0;
      i_d   = '0;
    end else if (seq_i.run) begin
      case (ctrl_i.aop)
        AOP_INIT: begin
          acc_d = acc_init;
          sq_d  = prod[2*HALF-1:0];
        end
        AOP_LO:  acc_d = acc_q + prod_ext;
        AOP_HI:  acc_d = acc_q + (prod_ext <<< HALF);
        default: acc_d = acc_q;
      endcase
      case (ctrl_i.act)
        ACT_SGN_L: sl_d = sm;
        ACT_CHK:   sr_d = sm;
        ACT_KLOOP: begin
          if (kmore) begin
            t_d = {t_q[XW-1:0], 1'b0};
            k_d = k_q + STEP_W'(1);
          end
        end
        ACT_MID: x_d = mid_sum[XW:1];
        ACT_DEC: begin
          i_d = i_next;
          // replaced end keeps its sign, so sl/sr stay valid
          if (!near_zero) begin
            if (sm == sl_q) begin
              lft_d = x_q;
            end else if (sm == sr_q) begin
              rgt_d = x_q;
            end
          end
        end
        default: begin
          i_d = i_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      i_q  <= '0;
      sl_q <= '0;
      sr_q <= '0;
    end else begin
      k_q  <= k_d;
      i_q  <= i_d;
      sl_q <= sl_d;
      sr_q <= sr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lft_q <= lft_d;
    rgt_q <= rgt_d;
    tol_q <= tol_d;
    t_q   <= t_d;
    x_q   <= x_d;
    sq_q  <= sq_d;
    acc_q <= acc_d;
  end

endmodule

### design/bcrf_sequencer.sv
// Microprogram sequencer: step counter, conditional jumps, run/finish control.
module bcrf_sequencer import bcrf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start,
  input  ctrl_t  ctrl_i,
  input  flags_t flags_i,
  output step_e  step_o,
  output seq_t   seq_o,
  output logic   busy
);

  logic  running_q, running_d;
  step_e pc_q, pc_d;
  logic  take, accept, finish;

  assign accept = start && !running_q;

  always_comb begin
    case (ctrl_i.jc)
      JC_KMORE: take = flags_i.kmore;
      JC_LOOP:  take = !flags_i.last;
      default:  take = 1'b0;
    endcase
  end

  assign finish = running_q
               && (((ctrl_i.act == ACT_CHK) && flags_i.same_sign)
                || ((ctrl_i.act == ACT_DEC) && flags_i.last));

  always_comb begin
    running_d = running_q;
    pc_d      = pc_q;
    if (accept) begin
      running_d = 1'b1;
      pc_d      = S_EVL0;
    end else if (running_q) begin
      if (finish) begin
        running_d = 1'b0;
        pc_d      = S_EVL0;
      end else if (take) begin
        pc_d = ctrl_i.target;
      end else begin
        pc_d = step_e'(4'(pc_q + 4'd1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      pc_q      <= S_EVL0;
    end else begin
      running_q <= running_d;
      pc_q      <= pc_d;
    end
  end

  assign step_o       = pc_q;
  assign busy         = running_q;
  assign seq_o.accept = accept;
  assign seq_o.run    = running_q;
  assign seq_o.finish = finish;

endmodule

### design/bisection_cubic_root_finder_unit.sv
// Top level of the bisection root finder for p(x) = x^3 + 2x^2 + 10x - 20.
//
// Pulse start while busy is low to hand over one item (bracket ends and
// tolerance, Q16.16). Exactly one result comes back on result_o, valid for
// a single cycle with done_o high; there is no backpressure, so sample it
// then. One item is worked on at a time. Each cubic evaluation uses one
// shared 33x33 multiplier in turn (x*x, then the low and high halves of
// x^2 times x+2s), with the linear and constant terms folded into the
// first accumulator load. After both ends are evaluated the run stops if
// they share a sign; else a step-count search picks k (at most 40), and
// each of the k bisection steps forms the midpoint, evaluates p there and
// moves the end whose sign p(mid) shares unless |p(mid)| is within the
// tolerance. A new item may be started in the cycle done_o is high.
//
// Control is microcoded: a 13-step program in a constant table drives the
// datapath, with conditional jumps for the step-count loop and the
// bisection loop.
`include "bisection_cubic_root_finder_unit_defines.svh"

module bisection_cubic_root_finder_unit import bcrf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  item_t in_i,
  output logic  done_o,
  output res_t  result_o
);

  step_e  step;
  ctrl_t  ctrl;
  flags_t flags;
  seq_t   seq;
  res_t   res_next;

  logic done_q, done_d;
  res_t res_q, res_d;

  bcrf_ucode_rom u_rom (
    .step_i (step),
    .ctrl_o (ctrl)
  );

  bcrf_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .ctrl_i  (ctrl),
    .flags_i (flags),
    .step_o  (step),
    .seq_o   (seq),
    .busy    (busy)
  );

  bcrf_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (in_i),
    .ctrl_i  (ctrl),
    .seq_i   (seq),
    .flags_o (flags),
    .res_o   (res_next)
  );

  // result register: captured on the finishing step, shown for one cycle
  assign done_d = seq.finish;
  assign res_d  = seq.finish ? res_next : res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  `BCRF_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `BCRF_ASSERT_IMP(a_done_idle, done_o, !busy, "result shown while still busy")
  `BCRF_ASSERT_IMP(a_steps_cap, done_o, result_o.steps_taken <= STEP_W'(MAX_ITER), "step count over cap")
  `BCRF_ASSERT_IMP(a_same_sign_zero, done_o && result_o.status == ST_SAME_SIGN, result_o.steps_taken == '0 && result_o.root_estimate == '0, "same-sign result not cleared")

endmodule
